// ----- sv/rtem_pkg.sv -----
// Package with item types, command and status codes, and control structs of the route table.
`timescale 1ns / 1ps

package rtem_pkg;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Next hop returned by anything but a lookup hit
  localparam logic signed [31:0] MISS_HOP = -32'sd1;

  // Bucket remainder cycles: reciprocal product, quotient times buckets, correction
  localparam int MOD_STEPS  = 3;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] dest_addr;
    logic signed [31:0] hop_in;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] hop_out;
    logic [1:0]         status;
  } rsp_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic mod_step;
    logic rd;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/route_table_exact_match_core.sv -----
// Top level of the exact-match route table: controller and datapath.
// Usage:
//   Request channel (req_valid/req_ready/req) takes one command item: add or
//   update a route, remove it, or look up the next hop of dest_addr.
//   Response channel (rsp_valid/rsp_ready/rsp) returns one item per command
//   with hop_out (-1 unless a lookup hits) and a status code.
//   The bucket is the key magnitude modulo BUCKETS, found by a reciprocal
//   multiply and one correcting subtract; a row holds WAYS entries.
// Sequence:
//   After an item is accepted, its remainder is formed, the bucket row is
//   read, and the ways are compared and the row written back. The next
//   item is accepted once the block is idle again, one at a time; the
//   remainder unit and the single row port of the bucket memories set that.
// Reset:
//   rst clears the control logic, then the valid rows are swept, one bucket
//   a cycle, up to the last bucket; req_ready stays low during the sweep.
// Stall:
//   The result sits in an output register; the next item is accepted and
//   worked on while it waits, and the block holds in its compare step until
//   the register is free.
`timescale 1ns / 1ps

module route_table_exact_match_core
  import rtem_pkg::*;
#(
  parameter int BUCKETS = 128,
  parameter int WAYS    = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rtem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rtem_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- sv/rtem_ctrl.sv -----
// Controller state machine of the route table: clear sweep, remainder steps, read and commit.
`timescale 1ns / 1ps

module rtem_ctrl
  import rtem_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_LOOK  = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [MOD_CNT_W-1:0] mod_cnt, mod_cnt_next;

  // Drive datapath commands from the current state
  always_comb begin
    cmd.clr_step = (state == S_CLEAR);
    cmd.load     = (state == S_IDLE) && req_valid;
    cmd.mod_step = (state == S_MOD);
    cmd.rd       = (state == S_READ);
    cmd.commit   = (state == S_LOOK) && stat.out_free;
  end

  assign req_ready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next   = state;
    mod_cnt_next = mod_cnt;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        mod_cnt_next = '0;
        if (req_valid) state_next = S_MOD;
      end
      S_MOD: begin
        mod_cnt_next = mod_cnt + MOD_CNT_W'(1);
        if (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1)) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_LOOK;
      end
      S_LOOK: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      mod_cnt <= '0;
    end else begin
      state   <= state_next;
      mod_cnt <= mod_cnt_next;
    end
  end

endmodule

// ----- sv/rtem_datapath.sv -----
// Datapath of the route table: bucket remainder, bucket memories, way compare and result register.
`timescale 1ns / 1ps

module rtem_datapath
  import rtem_pkg::*;
#(
  parameter int BUCKETS = 128,
  parameter int WAYS    = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  input  req_item_t  req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_item_t  rsp
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [31:0]      RECIP    = 32'(64'h0000_0000_FFFF_FFFF / 64'(BUCKETS));
  localparam logic [31:0]      BKT_K    = 32'(BUCKETS);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  // Bucket memories: keys and hops per row, valid bits per row
  logic [WAYS-1:0][31:0] key_mem [BUCKETS];
  logic [WAYS-1:0][31:0] hop_mem [BUCKETS];
  logic [WAYS-1:0]       vld_mem [BUCKETS];

  logic [1:0]            cmd_r;
  logic [31:0]           key_r;
  logic [31:0]           hop_r;
  logic [31:0]           mag_r;
  logic [63:0]           prod;
  logic [31:0]           qb;
  logic [BKT_W-1:0]      rem;
  logic [BKT_W-1:0]      clr_addr;
  logic [WAYS-1:0][31:0] key_rd;
  logic [WAYS-1:0][31:0] hop_rd;
  logic [WAYS-1:0]       vld_rd;

  logic [31:0]           din_u;
  logic [31:0]           mag;
  logic [31:0]           diff;
  logic [31:0]           diff_fix;

  logic                  hit;
  logic [WAY_W-1:0]      hit_way;
  logic                  any_free;
  logic [WAY_W-1:0]      free_way;
  logic [WAYS-1:0][31:0] key_new;
  logic [WAYS-1:0][31:0] hop_new;
  logic [WAYS-1:0]       vld_new;
  logic                  kh_we;
  logic                  vld_we;
  rsp_item_t             res;

  // Magnitude of the signed key
  assign din_u = req.dest_addr;
  assign mag   = din_u[31] ? (~din_u + 32'd1) : din_u;

  // The estimated quotient is low by at most one, so one subtract corrects it
  assign diff     = mag_r - qb;
  assign diff_fix = (diff >= BKT_K) ? (diff - BKT_K) : diff;

  // Capture the item and advance the remainder pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= req.cmd;
      key_r <= req.dest_addr;
      hop_r <= req.hop_in;
      mag_r <= mag;
    end else if (cmd.mod_step) begin
      prod <= 64'(mag_r) * 64'(RECIP);
      qb   <= 32'(prod[63:32] * BKT_K);
      rem  <= diff_fix[BKT_W-1:0];
    end
  end

  // Sweep the valid rows after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step && (clr_addr != BKT_LAST)) begin
      clr_addr <= clr_addr + BKT_W'(1);
    end
  end

  assign stat.clr_last = (clr_addr == BKT_LAST);

  // Read the bucket row
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      key_rd <= key_mem[rem];
      hop_rd <= hop_mem[rem];
      vld_rd <= vld_mem[rem];
    end
  end

  // Compare the ways and decide the outcome
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_rd[w] && (key_rd[w] == key_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!vld_rd[w]) begin
        any_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end

    key_new     = key_rd;
    hop_new     = hop_rd;
    vld_new     = vld_rd;
    kh_we       = 1'b0;
    vld_we      = 1'b0;
    res.hop_out = MISS_HOP;
    res.status  = ST_ABSENT;

    case (cmd_r)
      CMD_ADD: begin
        if (hit) begin
          hop_new[hit_way] = hop_r;
          kh_we            = 1'b1;
          res.status       = ST_UPDATED;
        end else if (any_free) begin
          key_new[free_way] = key_r;
          hop_new[free_way] = hop_r;
          vld_new[free_way] = 1'b1;
          kh_we             = 1'b1;
          vld_we            = 1'b1;
          res.status        = ST_OK;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          vld_new[hit_way] = 1'b0;
          vld_we           = 1'b1;
          res.status       = ST_OK;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          res.hop_out = hop_rd[hit_way];
          res.status  = ST_OK;
        end
      end
      default: begin
        res.status = ST_ABSENT;
      end
    endcase
  end

  // Write back the row on commit
  always_ff @(posedge clk) begin
    if (cmd.commit && kh_we) begin
      key_mem[rem] <= key_new;
      hop_mem[rem] <= hop_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vld_mem[clr_addr] <= '0;
    end else if (cmd.commit && vld_we) begin
      vld_mem[rem] <= vld_new;
    end
  end

  // Hold the result item until taken
  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= res;
  end

endmodule
